// ----- rtl/cpct_pkg.sv -----
// Shared constants, payload types and codes for the collider pair contact tracker.
package cpct_pkg;

   localparam int MAX_COLLIDERS = 16;
   localparam int PAIR_COUNT    = MAX_COLLIDERS * MAX_COLLIDERS;
   localparam int PAIR_IDX_W    = $clog2(PAIR_COUNT);

   localparam int ID_W       = 4;
   localparam int SHAPE_W    = 2;
   localparam int POS_W      = 24;
   localparam int SIZE_W     = 16;
   localparam int SIZE_SCALE = 100;

   // 65535 * 100 fits in 23 bits
   localparam int SCALED_W = 23;
   // doubled centre: 2*pos + scaled size
   localparam int CTR_W    = 26;
   localparam int DIST_W   = 26;
   localparam int SUM_W    = SCALED_W + 1;
   localparam int SQ_W     = 2 * DIST_W;
   localparam int RSQ_W    = 2 * SUM_W;
   localparam int ACC_W    = SQ_W + 1;

   localparam logic [SHAPE_W-1:0] SHAPE_RECT   = 2'd0;
   localparam logic [SHAPE_W-1:0] SHAPE_CIRCLE = 2'd1;

   typedef enum logic [1:0] {
      EVT_NONE  = 2'd0,
      EVT_ENTER = 2'd1,
      EVT_STAY  = 2'd2,
      EVT_EXIT  = 2'd3
   } contact_event_type;

   typedef enum logic [1:0] {
      KIND_NONE      = 2'd0,
      KIND_RECT_RECT = 2'd1,
      KIND_CIRC_CIRC = 2'd2,
      KIND_RECT_CIRC = 2'd3
   } pair_kind_type;

   typedef struct packed {
      logic [ID_W-1:0]          left_id;
      logic [ID_W-1:0]          right_id;
      logic [SHAPE_W-1:0]       left_shape;
      logic [SHAPE_W-1:0]       right_shape;
      logic signed [POS_W-1:0]  left_x;
      logic signed [POS_W-1:0]  left_y;
      logic signed [POS_W-1:0]  right_x;
      logic signed [POS_W-1:0]  right_y;
      logic [SIZE_W-1:0]        left_w;
      logic [SIZE_W-1:0]        left_h;
      logic [SIZE_W-1:0]        right_w;
      logic [SIZE_W-1:0]        right_h;
   } req_payload_type;

   typedef struct packed {
      logic              touching;
      contact_event_type contact_event;
   } rsp_payload_type;

   // hit pipeline to contact stage
   typedef struct packed {
      logic [ID_W-1:0] left_id;
      logic [ID_W-1:0] right_id;
      logic            hit;
   } pipe_result_type;

endpackage

// ----- rtl/cpct_hit_pipe.sv -----
// Five-stage intersection pipeline: scale and centre, distances, bounds, squares, decide.
module cpct_hit_pipe (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  cpct_pkg::req_payload_type in_data,
   output logic                      out_valid,
   input  logic                      out_ready,
   output cpct_pkg::pipe_result_type out_data
);

   typedef struct packed {
      logic [cpct_pkg::ID_W-1:0]            left_id;
      logic [cpct_pkg::ID_W-1:0]            right_id;
      cpct_pkg::pair_kind_type              kind;
      logic                                 circle_left;
      logic signed [cpct_pkg::CTR_W-1:0]    lcx;
      logic signed [cpct_pkg::CTR_W-1:0]    lcy;
      logic signed [cpct_pkg::CTR_W-1:0]    rcx;
      logic signed [cpct_pkg::CTR_W-1:0]    rcy;
      logic [cpct_pkg::SCALED_W-1:0]        lsw;
      logic [cpct_pkg::SCALED_W-1:0]        lsh;
      logic [cpct_pkg::SCALED_W-1:0]        rsw;
      logic [cpct_pkg::SCALED_W-1:0]        rsh;
   } stage_b_type;

   typedef struct packed {
      logic [cpct_pkg::ID_W-1:0]     left_id;
      logic [cpct_pkg::ID_W-1:0]     right_id;
      cpct_pkg::pair_kind_type       kind;
      logic [cpct_pkg::DIST_W-1:0]   dx;
      logic [cpct_pkg::DIST_W-1:0]   dy;
      logic [cpct_pkg::SUM_W-1:0]    wsum;
      logic [cpct_pkg::SUM_W-1:0]    hsum;
      logic [cpct_pkg::SCALED_W-1:0] hw;
      logic [cpct_pkg::SCALED_W-1:0] hh;
      logic [cpct_pkg::SCALED_W-1:0] rad;
   } stage_c_type;

   typedef struct packed {
      logic [cpct_pkg::ID_W-1:0]   left_id;
      logic [cpct_pkg::ID_W-1:0]   right_id;
      cpct_pkg::pair_kind_type     kind;
      logic                        rr_hit;
      logic                        reject;
      logic                        in_band;
      logic [cpct_pkg::DIST_W-1:0] op_a;
      logic [cpct_pkg::DIST_W-1:0] op_b;
      logic [cpct_pkg::SUM_W-1:0]  op_c;
   } stage_d_type;

   typedef struct packed {
      logic [cpct_pkg::ID_W-1:0]  left_id;
      logic [cpct_pkg::ID_W-1:0]  right_id;
      cpct_pkg::pair_kind_type    kind;
      logic                       rr_hit;
      logic                       reject;
      logic                       in_band;
      logic [cpct_pkg::SQ_W-1:0]  sq_a;
      logic [cpct_pkg::SQ_W-1:0]  sq_b;
      logic [cpct_pkg::RSQ_W-1:0] sq_c;
   } stage_e_type;

   function automatic logic [cpct_pkg::SCALED_W-1:0] scale_size(
      input logic [cpct_pkg::SIZE_W-1:0] w);
      scale_size = cpct_pkg::SCALED_W'(w) * cpct_pkg::SCALED_W'(cpct_pkg::SIZE_SCALE);
   endfunction

   function automatic logic signed [cpct_pkg::CTR_W-1:0] centre2(
      input logic signed [cpct_pkg::POS_W-1:0] p,
      input logic [cpct_pkg::SCALED_W-1:0]     s);
      centre2 = $signed({{(cpct_pkg::CTR_W-cpct_pkg::POS_W-1){p[cpct_pkg::POS_W-1]}}, p, 1'b0})
              + $signed({{(cpct_pkg::CTR_W-cpct_pkg::SCALED_W){1'b0}}, s});
   endfunction

   function automatic logic [cpct_pkg::DIST_W-1:0] abs_diff(
      input logic signed [cpct_pkg::CTR_W-1:0] a,
      input logic signed [cpct_pkg::CTR_W-1:0] b);
      logic signed [cpct_pkg::CTR_W:0] d;
      logic signed [cpct_pkg::CTR_W:0] m;
      d = {a[cpct_pkg::CTR_W-1], a} - {b[cpct_pkg::CTR_W-1], b};
      m = d[cpct_pkg::CTR_W] ? -d : d;
      abs_diff = m[cpct_pkg::DIST_W-1:0];
   endfunction

   cpct_pkg::req_payload_type a_ff, a_in;
   stage_b_type               b_ff, b_in, b_next;
   stage_c_type               c_ff, c_in, c_next;
   stage_d_type               d_ff, d_in, d_next;
   stage_e_type               e_ff, e_in, e_next;
   logic a_valid_ff, a_valid_in, b_valid_ff, b_valid_in, c_valid_ff, c_valid_in;
   logic d_valid_ff, d_valid_in, e_valid_ff, e_valid_in;
   logic a_load, b_load, c_load, d_load, e_load;

   // a stage loads when it is empty or its content moves on
   assign e_load   = !e_valid_ff || out_ready;
   assign d_load   = !d_valid_ff || e_load;
   assign c_load   = !c_valid_ff || d_load;
   assign b_load   = !b_valid_ff || c_load;
   assign a_load   = !a_valid_ff || b_load;
   assign in_ready = a_load;

   // stage A -> B: scale sizes, doubled centres, classify pair
   always_comb begin
      logic l_rect, l_circ, r_rect, r_circ;
      l_rect = (a_ff.left_shape == cpct_pkg::SHAPE_RECT);
      l_circ = (a_ff.left_shape == cpct_pkg::SHAPE_CIRCLE);
      r_rect = (a_ff.right_shape == cpct_pkg::SHAPE_RECT);
      r_circ = (a_ff.right_shape == cpct_pkg::SHAPE_CIRCLE);
      b_next.left_id     = a_ff.left_id;
      b_next.right_id    = a_ff.right_id;
      b_next.circle_left = l_circ;
      b_next.lsw         = scale_size(a_ff.left_w);
      b_next.lsh         = scale_size(a_ff.left_h);
      b_next.rsw         = scale_size(a_ff.right_w);
      b_next.rsh         = scale_size(a_ff.right_h);
      b_next.lcx         = centre2(a_ff.left_x, b_next.lsw);
      b_next.lcy         = centre2(a_ff.left_y, b_next.lsh);
      b_next.rcx         = centre2(a_ff.right_x, b_next.rsw);
      b_next.rcy         = centre2(a_ff.right_y, b_next.rsh);
      if (l_rect && r_rect) begin
         b_next.kind = cpct_pkg::KIND_RECT_RECT;
      end else if (l_circ && r_circ) begin
         b_next.kind = cpct_pkg::KIND_CIRC_CIRC;
      end else if ((l_rect && r_circ) || (l_circ && r_rect)) begin
         b_next.kind = cpct_pkg::KIND_RECT_CIRC;
      end else begin
         b_next.kind = cpct_pkg::KIND_NONE;
      end
   end

   // stage B -> C: centre distances, extent sums, rect/circle roles
   always_comb begin
      c_next.left_id  = b_ff.left_id;
      c_next.right_id = b_ff.right_id;
      c_next.kind     = b_ff.kind;
      c_next.dx       = abs_diff(b_ff.lcx, b_ff.rcx);
      c_next.dy       = abs_diff(b_ff.lcy, b_ff.rcy);
      c_next.wsum     = cpct_pkg::SUM_W'(b_ff.lsw) + cpct_pkg::SUM_W'(b_ff.rsw);
      c_next.hsum     = cpct_pkg::SUM_W'(b_ff.lsh) + cpct_pkg::SUM_W'(b_ff.rsh);
      c_next.hw       = b_ff.circle_left ? b_ff.rsw : b_ff.lsw;
      c_next.hh       = b_ff.circle_left ? b_ff.rsh : b_ff.lsh;
      c_next.rad      = b_ff.circle_left ? b_ff.lsw : b_ff.rsw;
   end

   // stage C -> D: bound checks and square operands
   always_comb begin
      logic [cpct_pkg::SUM_W-1:0]  reach_x, reach_y;
      logic [cpct_pkg::DIST_W-1:0] hw_ext, hh_ext, ex, ey;
      reach_x = cpct_pkg::SUM_W'(c_ff.hw) + cpct_pkg::SUM_W'(c_ff.rad);
      reach_y = cpct_pkg::SUM_W'(c_ff.hh) + cpct_pkg::SUM_W'(c_ff.rad);
      hw_ext  = cpct_pkg::DIST_W'(c_ff.hw);
      hh_ext  = cpct_pkg::DIST_W'(c_ff.hh);
      ex      = (c_ff.dx > hw_ext) ? c_ff.dx - hw_ext : '0;
      ey      = (c_ff.dy > hh_ext) ? c_ff.dy - hh_ext : '0;
      d_next.left_id  = c_ff.left_id;
      d_next.right_id = c_ff.right_id;
      d_next.kind     = c_ff.kind;
      d_next.rr_hit   = (c_ff.dx < cpct_pkg::DIST_W'(c_ff.wsum))
                     && (c_ff.dy < cpct_pkg::DIST_W'(c_ff.hsum));
      d_next.reject   = (c_ff.dx > cpct_pkg::DIST_W'(reach_x))
                     || (c_ff.dy > cpct_pkg::DIST_W'(reach_y));
      d_next.in_band  = (c_ff.dx <= hw_ext) || (c_ff.dy <= hh_ext);
      if (c_ff.kind == cpct_pkg::KIND_CIRC_CIRC) begin
         d_next.op_a = c_ff.dx;
         d_next.op_b = c_ff.dy;
         d_next.op_c = c_ff.wsum;
      end else begin
         d_next.op_a = ex;
         d_next.op_b = ey;
         d_next.op_c = cpct_pkg::SUM_W'(c_ff.rad);
      end
   end

   // stage D -> E: squares
   always_comb begin
      e_next.left_id  = d_ff.left_id;
      e_next.right_id = d_ff.right_id;
      e_next.kind     = d_ff.kind;
      e_next.rr_hit   = d_ff.rr_hit;
      e_next.reject   = d_ff.reject;
      e_next.in_band  = d_ff.in_band;
      e_next.sq_a     = cpct_pkg::SQ_W'(d_ff.op_a) * cpct_pkg::SQ_W'(d_ff.op_a);
      e_next.sq_b     = cpct_pkg::SQ_W'(d_ff.op_b) * cpct_pkg::SQ_W'(d_ff.op_b);
      e_next.sq_c     = cpct_pkg::RSQ_W'(d_ff.op_c) * cpct_pkg::RSQ_W'(d_ff.op_c);
   end

   // stage E: final decision
   always_comb begin
      logic [cpct_pkg::ACC_W-1:0] dist_sq;
      logic                       sq_ok;
      dist_sq = cpct_pkg::ACC_W'(e_ff.sq_a) + cpct_pkg::ACC_W'(e_ff.sq_b);
      sq_ok   = dist_sq <= cpct_pkg::ACC_W'(e_ff.sq_c);
      out_data.left_id  = e_ff.left_id;
      out_data.right_id = e_ff.right_id;
      unique case (e_ff.kind)
         cpct_pkg::KIND_RECT_RECT: out_data.hit = e_ff.rr_hit;
         cpct_pkg::KIND_CIRC_CIRC: out_data.hit = sq_ok;
         cpct_pkg::KIND_RECT_CIRC: out_data.hit = !e_ff.reject && (e_ff.in_band || sq_ok);
         default:                  out_data.hit = 1'b0;
      endcase
   end
   assign out_valid = e_valid_ff;

   always_comb begin
      a_in       = a_load ? in_data : a_ff;
      b_in       = b_load ? b_next : b_ff;
      c_in       = c_load ? c_next : c_ff;
      d_in       = d_load ? d_next : d_ff;
      e_in       = e_load ? e_next : e_ff;
      a_valid_in = a_load ? in_valid : a_valid_ff;
      b_valid_in = b_load ? a_valid_ff : b_valid_ff;
      c_valid_in = c_load ? b_valid_ff : c_valid_ff;
      d_valid_in = d_load ? c_valid_ff : d_valid_ff;
      e_valid_in = e_load ? d_valid_ff : e_valid_ff;
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      c_ff <= c_in;
      d_ff <= d_in;
      e_ff <= e_in;
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= b_valid_in;
         c_valid_ff <= c_valid_in;
         d_valid_ff <= d_valid_in;
         e_valid_ff <= e_valid_in;
      end
   end

endmodule

// ----- rtl/collider_pair_contact_tracker.sv -----
// Collider pair contact tracker: intersection pipeline, per-pair contact flags, output register.
//
// Takes one request per clock while req_stall is low and returns one response per request,
// in order. A request passes five pipeline stages (size scaling and centres, centre
// distances, bound checks, 26x26-bit squares, final compare), then a lookup stage that
// reads the pair's contact flag from a 256x1 memory, then the contact stage, which writes
// the flag back as it loads the output register. A flag written by the request ahead in
// the same cycle as the read is forwarded, so a pair repeated in back-to-back requests sees
// the previous request's update. After reset the flag memory is cleared one entry per
// cycle, and req_stall stays high until all 256 entries are cleared. Stalls hold each
// stage, and bubbles fill while the response waits.
module collider_pair_contact_tracker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  cpct_pkg::req_payload_type req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output cpct_pkg::rsp_payload_type rsp_data
);

   function automatic logic [cpct_pkg::PAIR_IDX_W-1:0] pair_index(
      input cpct_pkg::pipe_result_type p);
      pair_index = cpct_pkg::PAIR_IDX_W'(int'(p.left_id) * cpct_pkg::MAX_COLLIDERS
                                         + int'(p.right_id));
   endfunction

   cpct_pkg::pipe_result_type pipe_data;
   logic                      pipe_valid, pipe_ready, req_ready, pipe_in_valid;
   logic                      commit, out_load, id_ok, was_set;
   logic [cpct_pkg::PAIR_IDX_W-1:0] rd_idx, wr_idx, mem_waddr;
   logic [cpct_pkg::PAIR_IDX_W-1:0] clear_idx_ff, clear_idx_in;
   logic                      clear_ff, clear_in;
   logic                      mem_we, mem_wdata, mem_rd_ff;
   logic                      contact_mem [cpct_pkg::PAIR_COUNT];
   cpct_pkg::pipe_result_type look_ff, look_in;
   logic                      look_valid_ff, look_valid_in, look_load;
   logic                      fwd_ff, fwd_in, fwd_bit_ff, fwd_bit_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   cpct_pkg::rsp_payload_type rsp_data_ff, rsp_data_in, rsp_next;

   cpct_hit_pipe u_hit_pipe (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (pipe_in_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (pipe_valid),
      .out_ready (pipe_ready),
      .out_data  (pipe_data)
   );

   // no request enters while the flag memory is being cleared
   assign pipe_in_valid = req_valid && !clear_ff;
   assign req_stall     = !req_ready || clear_ff;
   assign out_load      = !rsp_valid_ff || !rsp_stall;
   assign look_load     = !look_valid_ff || out_load;
   assign pipe_ready    = look_load;
   assign commit        = look_valid_ff && out_load;

   assign rd_idx   = pair_index(pipe_data);
   assign wr_idx   = pair_index(look_ff);
   assign id_ok    = (int'(look_ff.left_id) < cpct_pkg::MAX_COLLIDERS)
                  && (int'(look_ff.right_id) < cpct_pkg::MAX_COLLIDERS);
   // an out-of-range pair reads as no contact and is never written
   assign was_set  = id_ok && (fwd_ff ? fwd_bit_ff : mem_rd_ff);

   assign mem_we    = clear_ff || (commit && id_ok);
   assign mem_waddr = clear_ff ? clear_idx_ff : wr_idx;
   assign mem_wdata = !clear_ff && look_ff.hit;

   always_comb begin
      rsp_next.touching = look_ff.hit;
      priority if (look_ff.hit && was_set) begin
         rsp_next.contact_event = cpct_pkg::EVT_STAY;
      end else if (look_ff.hit) begin
         rsp_next.contact_event = cpct_pkg::EVT_ENTER;
      end else if (was_set) begin
         rsp_next.contact_event = cpct_pkg::EVT_EXIT;
      end else begin
         rsp_next.contact_event = cpct_pkg::EVT_NONE;
      end
   end

   always_comb begin
      clear_in      = clear_ff;
      clear_idx_in  = clear_idx_ff;
      look_valid_in = look_valid_ff;
      look_in       = look_ff;
      fwd_in        = fwd_ff;
      fwd_bit_in    = fwd_bit_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      if (clear_ff) begin
         clear_idx_in = clear_idx_ff + cpct_pkg::PAIR_IDX_W'(1);
         if (clear_idx_ff == cpct_pkg::PAIR_IDX_W'(cpct_pkg::PAIR_COUNT - 1)) begin
            clear_in = 1'b0;
         end
      end
      if (look_load) begin
         look_valid_in = pipe_valid;
         look_in       = pipe_data;
         // the request ahead writes this pair's flag on the same edge as the read
         fwd_in        = commit && id_ok && (wr_idx == rd_idx);
         fwd_bit_in    = look_ff.hit;
      end
      if (out_load) begin
         rsp_valid_in = look_valid_ff;
         rsp_data_in  = rsp_next;
      end
   end

   always_ff @(posedge clock) begin
      if (look_load) begin
         mem_rd_ff <= contact_mem[rd_idx];
      end
      if (mem_we) begin
         contact_mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      look_ff     <= look_in;
      fwd_ff      <= fwd_in;
      fwd_bit_ff  <= fwd_bit_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         clear_ff      <= 1'b1;
         clear_idx_ff  <= '0;
         look_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         clear_ff      <= clear_in;
         clear_idx_ff  <= clear_idx_in;
         look_valid_ff <= look_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_stall_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clear_ff |-> req_stall)
      else $error("request accepted while contact flags are being cleared");

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   a_event_matches_touch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.touching == (rsp_data.contact_event == cpct_pkg::EVT_ENTER
                                       || rsp_data.contact_event == cpct_pkg::EVT_STAY))
      else $error("contact event disagrees with touching");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff && clear_ff)
      else $error("state not cleared by reset");

endmodule

// ----- bench/collider_pair_contact_tracker_tb.sv -----
// Self-checking bench for the collider pair contact tracker: shape tests and contact events.
module collider_pair_contact_tracker_tb;
   import cpct_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 20;

   logic            clock     = 1'b0;
   logic            reset     = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_data  = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_data;

   bit              contact_flags [PAIR_COUNT];
   rsp_payload_type expected_contacts [$];
   int              mismatch_count = 0;
   int              quiet_cycles   = 0;
   bit              gaps_on        = 1'b1;
   req_payload_type last_request   = '0;

   collider_pair_contact_tracker dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic longint abs_diff(input longint a, input longint b);
      return (a > b) ? a - b : b - a;
   endfunction

   // clamped corner test, doubled coordinates: rect centre/half-extents, circle centre/radius
   function automatic bit circle_meets_rect(input longint crx, input longint cry,
                                            input longint hw, input longint hh,
                                            input longint ccx, input longint ccy,
                                            input longint r);
      longint dx, dy, ex, ey;
      dx = abs_diff(ccx, crx);
      dy = abs_diff(ccy, cry);
      if (dx > hw + r || dy > hh + r) return 1'b0;
      if (dx <= hw || dy <= hh) return 1'b1;
      ex = dx - hw;
      ey = dy - hh;
      return (ex * ex + ey * ey) <= r * r;
   endfunction

   // intersection plus contact flag update for one request
   function automatic rsp_payload_type predict_contact(input req_payload_type p);
      longint          lw, lh, rw, rh, lcx, lcy, rcx, rcy, ddx, ddy, rsum;
      bit              hit, was, in_range;
      int              idx;
      rsp_payload_type r;
      lw  = longint'(p.left_w) * SIZE_SCALE;
      lh  = longint'(p.left_h) * SIZE_SCALE;
      rw  = longint'(p.right_w) * SIZE_SCALE;
      rh  = longint'(p.right_h) * SIZE_SCALE;
      lcx = 2 * longint'($signed(p.left_x)) + lw;
      lcy = 2 * longint'($signed(p.left_y)) + lh;
      rcx = 2 * longint'($signed(p.right_x)) + rw;
      rcy = 2 * longint'($signed(p.right_y)) + rh;
      hit = 1'b0;
      if (p.left_shape == SHAPE_RECT && p.right_shape == SHAPE_RECT) begin
         hit = abs_diff(lcx, rcx) < lw + rw && abs_diff(lcy, rcy) < lh + rh;
      end else if (p.left_shape == SHAPE_CIRCLE && p.right_shape == SHAPE_CIRCLE) begin
         ddx  = abs_diff(lcx, rcx);
         ddy  = abs_diff(lcy, rcy);
         rsum = lw + rw;
         hit  = (ddx * ddx + ddy * ddy) <= rsum * rsum;
      end else if (p.left_shape == SHAPE_RECT && p.right_shape == SHAPE_CIRCLE) begin
         hit = circle_meets_rect(lcx, lcy, lw, lh, rcx, rcy, rw);
      end else if (p.left_shape == SHAPE_CIRCLE && p.right_shape == SHAPE_RECT) begin
         hit = circle_meets_rect(rcx, rcy, rw, rh, lcx, lcy, lw);
      end
      in_range = p.left_id < MAX_COLLIDERS && p.right_id < MAX_COLLIDERS;
      idx = int'(p.left_id) * MAX_COLLIDERS + int'(p.right_id);
      was = in_range ? contact_flags[idx] : 1'b0;
      r.touching = hit;
      if (hit) begin
         if (was) r.contact_event = EVT_STAY;
         else r.contact_event = EVT_ENTER;
         if (in_range) contact_flags[idx] = 1'b1;
      end else if (was) begin
         r.contact_event = EVT_EXIT;
         contact_flags[idx] = 1'b0;
      end else begin
         r.contact_event = EVT_NONE;
      end
      return r;
   endfunction

   function automatic req_payload_type build_request(
         input int lid, input int rid, input int lshape, input int rshape,
         input int lx, input int ly, input int rx, input int ry,
         input int lw, input int lh, input int rw, input int rh);
      req_payload_type p;
      p.left_id     = lid[ID_W-1:0];
      p.right_id    = rid[ID_W-1:0];
      p.left_shape  = lshape[SHAPE_W-1:0];
      p.right_shape = rshape[SHAPE_W-1:0];
      p.left_x      = lx[POS_W-1:0];
      p.left_y      = ly[POS_W-1:0];
      p.right_x     = rx[POS_W-1:0];
      p.right_y     = ry[POS_W-1:0];
      p.left_w      = lw[SIZE_W-1:0];
      p.left_h      = lh[SIZE_W-1:0];
      p.right_w     = rw[SIZE_W-1:0];
      p.right_h     = rh[SIZE_W-1:0];
      return p;
   endfunction

   // mostly nearby pairs from a small id pool so contacts start, hold and end
   function automatic req_payload_type random_request(input bit well_formed);
      req_payload_type p;
      int              bx, by, sz [4];
      logic [191:0]    raw;
      if (!well_formed) begin
         raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
         p = raw[$bits(req_payload_type)-1:0];
         return p;
      end
      foreach (sz[i]) begin
         if ($urandom_range(0, 9) == 0) sz[i] = $urandom_range(0, 65535);
         else sz[i] = $urandom_range(0, 1023);
      end
      bx = $urandom_range(0, 8000000) - 4000000;
      by = $urandom_range(0, 8000000) - 4000000;
      p = build_request($urandom_range(0, 3), $urandom_range(0, 3),
                        ($urandom_range(0, 15) == 0) ? $urandom_range(2, 3)
                                                     : $urandom_range(0, 1),
                        ($urandom_range(0, 15) == 0) ? $urandom_range(2, 3)
                                                     : $urandom_range(0, 1),
                        bx, by,
                        bx + $urandom_range(0, 240000) - 120000,
                        by + $urandom_range(0, 240000) - 120000,
                        sz[0], sz[1], sz[2], sz[3]);
      return p;
   endfunction

   // valid stays high across back-to-back requests; only one assignment per edge
   task automatic send_request(input req_payload_type p);
      while (gaps_on && $urandom_range(0, 99) < 37) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= p;
      do @(posedge clock); while (req_stall);
      expected_contacts.push_back(predict_contact(p));
      last_request = p;
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_contacts.size() != 0);
   endtask

   task automatic test_directed_cases();
      // rect-rect: overlap, hold, then edges just touching (strict) twice: exit, then none
      send_request(build_request(1, 2, 0, 0, 0, 0, 12800, 0, 256, 256, 256, 256));
      send_request(build_request(1, 2, 0, 0, 0, 0, 12800, 0, 256, 256, 256, 256));
      send_request(build_request(1, 2, 0, 0, 0, 0, 25600, 0, 256, 256, 256, 256));
      send_request(build_request(1, 2, 0, 0, 0, 0, 25600, 0, 256, 256, 256, 256));
      // circle-circle: distance equal to radius sum, then one step farther
      send_request(build_request(3, 4, 1, 1, 0, 0, 25600, 0, 256, 256, 256, 256));
      send_request(build_request(3, 4, 1, 1, 0, 0, 25601, 0, 256, 256, 256, 256));
      // rect-circle near the corner: inside the corner arc, then outside it
      send_request(build_request(5, 6, 0, 1, 0, 0, 20000, 20000, 256, 256, 256, 256));
      send_request(build_request(5, 6, 0, 1, 0, 0, 24000, 24000, 256, 256, 256, 256));
      // circle on the left side
      send_request(build_request(6, 5, 1, 0, 20000, 20000, 0, 0, 256, 256, 256, 256));
      send_request(build_request(6, 5, 1, 0, 24000, 24000, 0, 0, 256, 256, 256, 256));
      // shape code none on either or both sides
      send_request(build_request(1, 3, 2, 0, 0, 0, 0, 0, 256, 256, 256, 256));
      send_request(build_request(1, 3, 1, 3, 0, 0, 0, 0, 256, 256, 256, 256));
      send_request(build_request(3, 1, 3, 2, 0, 0, 0, 0, 256, 256, 256, 256));
      // same id on both sides
      send_request(build_request(7, 7, 0, 0, 100, 100, 100, 100, 512, 512, 512, 512));
      // mostly zero extents at one point
      send_request(build_request(8, 8, 0, 0, 5000, 5000, 5000, 5000, 0, 0, 0, 0));
      send_request(build_request(9, 10, 1, 1, 5000, 5000, 5000, 5000, 0, 0, 0, 0));
      send_request(build_request(11, 12, 0, 1, 5000, 5000, 5000, 5000, 0, 0, 0, 0));
      send_request(build_request(12, 11, 1, 0, -5000, 0, -5000, 0, 0, 7, 0, 0));
      // position and size extremes
      send_request(build_request(15, 15, 0, 0, -8388608, -8388608, 8388607, 8388607,
                                 65535, 65535, 65535, 65535));
      send_request(build_request(15, 0, 1, 1, -8388608, -8388608, -8388608, -8388608,
                                 65535, 65535, 65535, 65535));
      send_request(build_request(0, 15, 1, 1, -8388608, -8388608, 8388607, 8388607,
                                 65535, 65535, 65535, 65535));
      send_request(build_request(14, 13, 0, 1, 8388607, -8388608, -8388608, 8388607,
                                 65535, 0, 65535, 0));
      send_request(build_request(13, 14, 1, 0, 8388607, 8388607, 8388607, 8388607,
                                 65535, 65535, 0, 0));
   endtask

   // one pair back to back so the flag update must forward to the next request
   task automatic test_repeated_pair();
      int rx;
      gaps_on = 1'b0;
      repeat (40) begin
         rx = $urandom_range(0, 1) ? 12800 : 60000;
         send_request(build_request(2, 3, 0, 0, 0, 0, rx, 0, 256, 256, 256, 256));
      end
      gaps_on = 1'b1;
   endtask

   task automatic test_random_pairs();
      req_payload_type p;
      int              shift;
      for (int n = 0; n < 600; n++) begin
         gaps_on = (n >= 150);
         if (n == 300) drain_responses();
         if ($urandom_range(0, 7) == 0) begin
            // same pair again, moved a little
            p = last_request;
            shift = $urandom_range(0, 200000) - 100000;
            p.right_x = p.right_x + shift[POS_W-1:0];
         end else begin
            p = random_request($urandom_range(0, 99) < 85);
         end
         send_request(p);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (rsp_valid && !rsp_stall) begin
            if (expected_contacts.size() == 0) begin
               $error("response with no request outstanding");
               mismatch_count++;
            end else begin
               if (rsp_data.touching !== expected_contacts[0].touching) begin
                  $error("touching: expected %0d, actual %0d",
                         expected_contacts[0].touching, rsp_data.touching);
                  mismatch_count++;
               end
               if (rsp_data.contact_event !== expected_contacts[0].contact_event) begin
                  $error("contact_event: expected %0d, actual %0d",
                         expected_contacts[0].contact_event, rsp_data.contact_event);
                  mismatch_count++;
               end
               void'(expected_contacts.pop_front());
            end
         end
         rsp_stall <= gaps_on && ($urandom_range(0, 99) < 37);
      end
   end

   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_repeated_pair();
      test_random_pairs();
      drain_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_contacts.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/cpct_pkg.sv
rtl/cpct_hit_pipe.sv
rtl/collider_pair_contact_tracker.sv
bench/collider_pair_contact_tracker_tb.sv
